### sv/tridiagonal_system_solver_defines.svh
// Assertion macros shared by the tridiagonal solver RTL.
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tss_pkg.sv
// Types, constants and saturation helpers of the tridiagonal solver.
package tss_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int FRAC_BITS  = 16;
	localparam int ADDR_W     = $clog2(MAX_ROWS);
	localparam int CNT_W      = $clog2(MAX_ROWS + 1);
	localparam int IDX_W      = 6;
	localparam int DIV_W      = 32 + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_A,
		OP_Z,
		OP_MUL_B,
		OP_NUM,
		OP_DIV_B,
		OP_WR_B,
		OP_DIV_A,
		OP_WR_A,
		OP_BS_INIT,
		OP_BS_MUL,
		OP_BS_ADD,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_Z,
		ST_MUL_B,
		ST_NUM,
		ST_DIV_B,
		ST_WAIT_B,
		ST_WR_B,
		ST_DIV_A,
		ST_WAIT_A,
		ST_WR_A,
		ST_BS_RD,
		ST_BS_INIT,
		ST_BS_MUL,
		ST_BS_ADD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t            op;
		logic [ADDR_W-1:0] rd_addr;
		logic [ADDR_W-1:0] wr_addr;
		logic              use_zero;
		logic [IDX_W-1:0]  emit_index;
		logic              emit_last;
		logic              emit_err;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic out_full;
		logic err;
	} dp_stat_t;

	typedef struct packed {
		logic [DIV_W-1:0] mag;
		logic             neg;
		logic             dz;
	} div_res_t;

	typedef struct packed {
		logic        err;
		logic [31:0] val;
	} sat_t;

	// Clamp a wide signed sum to 32 bits.
	function automatic sat_t sat_sum(input logic signed [64:0] v);
		sat_t r;
		r.err = 1'b0;
		r.val = v[31:0];
		if (v > 65'sh0_7FFF_FFFF) begin
			r.err = 1'b1;
			r.val = 32'h7FFF_FFFF;
		end else if (v < -65'sh0_8000_0000) begin
			r.err = 1'b1;
			r.val = 32'h8000_0000;
		end
		return r;
	endfunction

	// Clamp a sign and magnitude quotient to 32 bits.
	function automatic sat_t sat_quot(input logic [DIV_W-1:0] mag, input logic neg);
		sat_t r;
		r.err = 1'b0;
		if (neg) begin
			if (mag > DIV_W'(33'h0_8000_0000)) begin
				r.err = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.val = 32'(-mag);
			end
		end else begin
			if (mag > DIV_W'(33'h0_7FFF_FFFF)) begin
				r.err = 1'b1;
				r.val = 32'h7FFF_FFFF;
			end else begin
				r.val = mag[31:0];
			end
		end
		return r;
	endfunction

endpackage

### sv/tss_div.sv
// Iterative restoring divider: (num * 2^FRAC_BITS) / den, one quotient bit per cycle.
module tss_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  num,
	input  logic signed [31:0]  den,
	output logic                busy,
	output logic                done,
	output tss_pkg::div_res_t   res
);

	logic [tss_pkg::DIV_W-1:0]     dvd_q;
	logic [32:0]                   rem_q;
	logic [31:0]                   den_q;
	logic [tss_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          neg_q;
	logic                          dz_q;
	logic                          nz_q;
	logic [32:0]                   rem_sh;
	logic                          fits;
	logic [31:0]                   num_abs;
	logic [31:0]                   den_abs;

	assign num_abs = num[31] ? 32'(-num) : num;
	assign den_abs = den[31] ? 32'(-den) : den;
	assign rem_sh  = {rem_q[31:0], dvd_q[tss_pkg::DIV_W-1]};
	assign fits    = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tss_pkg::DIV_CNT_W'(tss_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tss_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_abs, {tss_pkg::FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= den_abs;
			dz_q  <= den == 32'sd0;
			nz_q  <= num != 32'sd0;
			// A zero divisor takes the numerator's sign alone.
			neg_q <= (den == 32'sd0) ? num[31] : (num[31] ^ den[31]);
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			dvd_q <= {dvd_q[tss_pkg::DIV_W-2:0], fits};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign res.mag = dz_q ? {tss_pkg::DIV_W{nz_q}} : dvd_q;
	assign res.neg = neg_q;
	assign res.dz  = dz_q;

endmodule

### sv/tss_dp.sv
// Datapath: row registers, ratio memories, multiplier, adder, divider, output register.
module tss_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  tss_pkg::dp_cmd_t   cmd,
	input  logic [127:0]       row_data,
	output tss_pkg::dp_stat_t  stat,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [39:0]        m_tdata,
	output logic               m_tlast,
	output logic               m_tuser
);

	logic signed [31:0] a_q, b_q, c_q, d_q;
	logic signed [31:0] z_q, num_q, x_q;
	logic signed [31:0] alpha_rd_q, beta_rd_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] alpha_mem [tss_pkg::MAX_ROWS];
	logic signed [31:0] beta_mem [tss_pkg::MAX_ROWS];

	logic signed [31:0] mul_x, mul_y;
	logic signed [63:0] prod_d;
	logic signed [63:0] prod_sh;
	logic signed [64:0] base65, sh65, sum65;
	logic signed [31:0] base;
	tss_pkg::sat_t      ssum;
	tss_pkg::sat_t      squot;
	logic               div_start;
	logic signed [31:0] div_num;
	logic               div_busy, div_done;
	tss_pkg::div_res_t  div_res;
	logic               step_err;

	logic               out_valid_q;
	logic [31:0]        out_value_q;
	logic [5:0]         out_index_q;
	logic               out_last_q;
	logic               out_err_q;

	always_comb begin
		mul_x = a_q;
		mul_y = cmd.use_zero ? 32'sd0 : alpha_rd_q;
		case (cmd.op)
			tss_pkg::OP_MUL_B: mul_y = cmd.use_zero ? 32'sd0 : beta_rd_q;
			tss_pkg::OP_BS_MUL: begin
				mul_x = alpha_rd_q;
				mul_y = x_q;
			end
			default: ;
		endcase
	end

	assign prod_d  = mul_x * mul_y;
	assign prod_sh = prod_q >>> tss_pkg::FRAC_BITS;
	assign sh65    = 65'(prod_sh);

	always_comb begin
		case (cmd.op)
			tss_pkg::OP_Z:   base = b_q;
			tss_pkg::OP_NUM: base = d_q;
			default:         base = beta_rd_q;
		endcase
	end

	assign base65 = 65'(base);
	assign sum65  = (cmd.op == tss_pkg::OP_NUM) ? (base65 - sh65) : (base65 + sh65);
	assign ssum   = tss_pkg::sat_sum(sum65);
	// The alpha ratio is the negated quotient c / z.
	assign squot  = tss_pkg::sat_quot(div_res.mag, div_res.neg ^ (cmd.op == tss_pkg::OP_WR_A));

	assign div_start = (cmd.op == tss_pkg::OP_DIV_B) || (cmd.op == tss_pkg::OP_DIV_A);
	assign div_num   = (cmd.op == tss_pkg::OP_DIV_A) ? c_q : num_q;

	tss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (z_q),
		.busy   (div_busy),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk) begin
		case (cmd.op)
			tss_pkg::OP_LOAD: begin
				a_q <= row_data[31:0];
				b_q <= row_data[63:32];
				c_q <= row_data[95:64];
				d_q <= row_data[127:96];
			end
			tss_pkg::OP_MUL_A, tss_pkg::OP_MUL_B, tss_pkg::OP_BS_MUL: prod_q <= prod_d;
			tss_pkg::OP_Z:       z_q   <= ssum.val;
			tss_pkg::OP_NUM:     num_q <= ssum.val;
			tss_pkg::OP_BS_INIT: x_q   <= beta_rd_q;
			tss_pkg::OP_BS_ADD:  x_q   <= ssum.val;
			tss_pkg::OP_WR_B:    beta_mem[cmd.wr_addr]  <= squot.val;
			tss_pkg::OP_WR_A:    alpha_mem[cmd.wr_addr] <= squot.val;
			default: ;
		endcase
		alpha_rd_q <= alpha_mem[cmd.rd_addr];
		beta_rd_q  <= beta_mem[cmd.rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == tss_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == tss_pkg::OP_EMIT) begin
			out_value_q <= x_q;
			out_index_q <= cmd.emit_index;
			out_last_q  <= cmd.emit_last;
			out_err_q   <= cmd.emit_err;
		end
	end

	always_comb begin
		case (cmd.op)
			tss_pkg::OP_Z, tss_pkg::OP_NUM, tss_pkg::OP_BS_ADD: step_err = ssum.err;
			tss_pkg::OP_WR_A, tss_pkg::OP_WR_B: step_err = squot.err | div_res.dz;
			default: step_err = 1'b0;
		endcase
	end

	assign stat.err      = step_err;
	assign stat.div_busy = div_busy;
	assign stat.div_done = div_done;
	assign stat.out_full = out_valid_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_index_q, out_value_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

### sv/tss_ctrl.sv
// Controller: sequences the forward sweep per row and the back substitution.
module tss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	output logic               s_tready,
	input  tss_pkg::dp_stat_t  stat,
	output tss_pkg::dp_cmd_t   cmd
);

	tss_pkg::ctrl_state_t         state_q, state_d;
	logic [tss_pkg::CNT_W-1:0]    row_count_q;
	logic [tss_pkg::ADDR_W-1:0]   idx_q;
	logic                         error_q;
	logic                         last_q;
	logic                         bs_first_q;
	logic                         accept;
	logic                         full;
	logic                         bs_phase;

	assign s_tready = state_q == tss_pkg::ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign full     = row_count_q >= tss_pkg::CNT_W'(tss_pkg::MAX_ROWS);
	assign bs_phase = (state_q == tss_pkg::ST_BS_RD) || (state_q == tss_pkg::ST_BS_INIT) ||
		(state_q == tss_pkg::ST_BS_MUL) || (state_q == tss_pkg::ST_BS_ADD) ||
		(state_q == tss_pkg::ST_EMIT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			tss_pkg::ST_IDLE: begin
				if (accept) begin
					if (full) begin
						state_d = s_tlast ? tss_pkg::ST_BS_RD : tss_pkg::ST_IDLE;
					end else begin
						state_d = tss_pkg::ST_MUL_A;
					end
				end
			end
			tss_pkg::ST_MUL_A: state_d = tss_pkg::ST_Z;
			tss_pkg::ST_Z:     state_d = tss_pkg::ST_MUL_B;
			tss_pkg::ST_MUL_B: state_d = tss_pkg::ST_NUM;
			tss_pkg::ST_NUM:   state_d = tss_pkg::ST_DIV_B;
			tss_pkg::ST_DIV_B: state_d = tss_pkg::ST_WAIT_B;
			tss_pkg::ST_WAIT_B: begin
				if (stat.div_done) state_d = tss_pkg::ST_WR_B;
			end
			tss_pkg::ST_WR_B:  state_d = last_q ? tss_pkg::ST_BS_RD : tss_pkg::ST_DIV_A;
			tss_pkg::ST_DIV_A: state_d = tss_pkg::ST_WAIT_A;
			tss_pkg::ST_WAIT_A: begin
				if (stat.div_done) state_d = tss_pkg::ST_WR_A;
			end
			tss_pkg::ST_WR_A:    state_d = tss_pkg::ST_IDLE;
			tss_pkg::ST_BS_RD:   state_d = bs_first_q ? tss_pkg::ST_BS_INIT : tss_pkg::ST_BS_MUL;
			tss_pkg::ST_BS_INIT: state_d = tss_pkg::ST_EMIT;
			tss_pkg::ST_BS_MUL:  state_d = tss_pkg::ST_BS_ADD;
			tss_pkg::ST_BS_ADD:  state_d = tss_pkg::ST_EMIT;
			tss_pkg::ST_EMIT: begin
				if (!stat.out_full) begin
					state_d = (idx_q == '0) ? tss_pkg::ST_IDLE : tss_pkg::ST_BS_RD;
				end
			end
			default: state_d = tss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op         = tss_pkg::OP_NONE;
		cmd.rd_addr    = bs_phase ? idx_q : (row_count_q[tss_pkg::ADDR_W-1:0] - 1'b1);
		cmd.wr_addr    = row_count_q[tss_pkg::ADDR_W-1:0];
		cmd.use_zero   = row_count_q == '0;
		cmd.emit_index = tss_pkg::IDX_W'(idx_q);
		cmd.emit_last  = idx_q == '0;
		cmd.emit_err   = error_q;
		case (state_q)
			tss_pkg::ST_IDLE:    cmd.op = accept ? tss_pkg::OP_LOAD : tss_pkg::OP_NONE;
			tss_pkg::ST_MUL_A:   cmd.op = tss_pkg::OP_MUL_A;
			tss_pkg::ST_Z:       cmd.op = tss_pkg::OP_Z;
			tss_pkg::ST_MUL_B:   cmd.op = tss_pkg::OP_MUL_B;
			tss_pkg::ST_NUM:     cmd.op = tss_pkg::OP_NUM;
			tss_pkg::ST_DIV_B:   cmd.op = tss_pkg::OP_DIV_B;
			tss_pkg::ST_WR_B:    cmd.op = tss_pkg::OP_WR_B;
			tss_pkg::ST_DIV_A:   cmd.op = tss_pkg::OP_DIV_A;
			tss_pkg::ST_WR_A:    cmd.op = tss_pkg::OP_WR_A;
			tss_pkg::ST_BS_INIT: cmd.op = tss_pkg::OP_BS_INIT;
			tss_pkg::ST_BS_MUL:  cmd.op = tss_pkg::OP_BS_MUL;
			tss_pkg::ST_BS_ADD:  cmd.op = tss_pkg::OP_BS_ADD;
			tss_pkg::ST_EMIT:    cmd.op = stat.out_full ? tss_pkg::OP_NONE : tss_pkg::OP_EMIT;
			default:             cmd.op = tss_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tss_pkg::ST_IDLE;
			row_count_q <= '0;
			idx_q       <= '0;
			error_q     <= 1'b0;
			last_q      <= 1'b0;
			bs_first_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (stat.err) error_q <= 1'b1;
			case (state_q)
				tss_pkg::ST_IDLE: begin
					if (accept) begin
						last_q <= s_tlast;
						// A row beyond the store is dropped; a dropped last row
						// still solves over the rows already stored.
						if (full) begin
							error_q    <= 1'b1;
							idx_q      <= tss_pkg::ADDR_W'(tss_pkg::MAX_ROWS - 1);
							bs_first_q <= 1'b1;
						end
					end
				end
				tss_pkg::ST_WR_B: begin
					idx_q      <= row_count_q[tss_pkg::ADDR_W-1:0];
					bs_first_q <= 1'b1;
				end
				tss_pkg::ST_WR_A: row_count_q <= row_count_q + 1'b1;
				tss_pkg::ST_EMIT: begin
					if (!stat.out_full) begin
						bs_first_q <= 1'b0;
						if (idx_q == '0) begin
							row_count_q <= '0;
							error_q     <= 1'b0;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### sv/tridiagonal_system_solver.sv
// Top level of the Thomas algorithm tridiagonal solver.
// Rows enter one item at a time on the slave stream, first row first, in signed
// Q16.16; s_tlast marks the final row. Between the accept of a non-final row
// and the next accept lie two passes of the shared bit-serial divider, for the
// beta and alpha ratios, plus the accept, four multiply and add steps and two
// memory writes. The final row takes only its beta ratio, after which back
// substitution emits the solution items while the output is free, highest index
// first, index zero marked by m_tlast; m_tuser flags a zero pivot, saturation or
// too many rows in the run.
// No new row is taken until the whole solution has been handed to the output
// register. Ratio memories need no clearing after reset.
`include "tridiagonal_system_solver_defines.svh"

module tridiagonal_system_solver (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] sub_diag, [63:32] main_diag, [95:64] super_diag, [127:96] rhs_value
	input  logic [127:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] solution_value, [37:32] solution_index, [39:38] zero
	output logic [39:0]  m_tdata,
	output logic         m_tlast,
	// [0] solve_error
	output logic         m_tuser
);

	tss_pkg::dp_cmd_t  cmd;
	tss_pkg::dp_stat_t stat;

	tss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.row_data (s_tdata),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	`TSS_ASSERT_NOW(a_last_is_index_zero, m_tvalid && m_tlast, m_tdata[37:32] == 6'd0, "final item has nonzero index")
	`TSS_ASSERT_NOW(a_no_row_while_dividing, stat.div_busy, !s_tready, "row accepted while divider busy")
	`TSS_ASSERT_NEXT(a_busy_after_mid_item, m_tvalid && m_tready && !m_tlast, !s_tready, "row accepted before solution done")

endmodule
